FILE: rtl/core/ppu_pkg.sv
// Shared types, constants and helpers for the particle pool update block.
package ppu_pkg;

  localparam int POOL_SIZE = 64;
  localparam int SLOT_W    = $clog2(POOL_SIZE);
  localparam int CNT_W     = SLOT_W + 1;
  localparam int ACC_W     = 50;

  localparam logic [16:0] ALPHA_ONE = 17'h10000;
  localparam logic [15:0] DT_MAX    = 16'hFFFF;

  typedef enum logic [2:0] {
    REG_ACCEL_X     = 3'd0,
    REG_ACCEL_Y     = 3'd1,
    REG_START_ALPHA = 3'd2,
    REG_ALPHA_RATE  = 3'd3,
    REG_BASE_COLOR  = 3'd4
  } cfg_idx_t;

  localparam logic KIND_SPAWN = 1'b0;
  localparam logic KIND_TICK  = 1'b1;

  typedef struct packed {
    logic               kind;
    logic        [31:0] now_ms;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;
  } in_item_t;

  typedef struct packed {
    logic               is_particle;
    logic               spawn_ok;
    logic        [5:0]  slot;
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic        [16:0] out_alpha;
    logic        [7:0]  out_color;
    logic               last;
  } out_item_t;

  // One pool slot as kept in the slot memory.
  typedef struct packed {
    logic        [31:0] birth_time;
    logic signed [31:0] origin_x;
    logic signed [31:0] origin_y;
    logic signed [31:0] origin_z;
    logic signed [31:0] speed_x;
    logic signed [31:0] speed_y;
    logic signed [31:0] speed_z;
    logic signed [31:0] pull_x;
    logic signed [31:0] pull_y;
    logic        [16:0] alpha_start;
    logic signed [31:0] alpha_slope;
    logic        [7:0]  palette;
  } slot_rec_t;

  localparam int REC_W = $bits(slot_rec_t);

  function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] hi;
    logic signed [ACC_W-1:0] lo;
    hi = ACC_W'(32'sh7FFFFFFF);
    lo = -ACC_W'(64'sh80000000);
    if (v > hi) begin
      sat32 = 32'sh7FFFFFFF;
    end else if (v < lo) begin
      sat32 = 32'sh80000000;
    end else begin
      sat32 = v[31:0];
    end
  endfunction

endpackage

FILE: rtl/core/particle_pool_update.sv
// Particle pool update: top level with slot memory, sequencer and shared multiplier.
//
// A pool of 64 particle slots. A spawn beat claims the last-freed hint slot
// when it is still free, else the lowest free slot found by a walk of one
// slot per cycle, and answers with one result beat (spawn_ok = 0 when the
// pool is full). A tick beat walks all slots in ascending order: a free slot
// is skipped, a live slot passes one slot memory read, nine steps of the
// shared 33x33 signed multiplier and its adders, and one hand-off. Each
// surviving particle yields one result beat, the last one flagged with last;
// particles whose alpha reaches zero die and become the hint. An empty tick
// answers one beat with is_particle = 0 and last = 1. Run time is dominated
// by the slot walk and the single multiplier. in_ready is high only while
// no item is in work; a finished result may wait in the output register
// while the next item is taken. Configuration writes are always taken and
// apply only to slots claimed after the write. The slot memory needs no
// clearing after reset.
module particle_pool_update (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  ppu_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output ppu_pkg::out_item_t  out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [2:0]          cfg_index,
  input  logic [31:0]         cfg_data
);
  import ppu_pkg::*;

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_FIND   = 7'b0000010,
    ST_SPUSH  = 7'b0000100,
    ST_RD     = 7'b0001000,
    ST_CALC   = 7'b0010000,
    ST_TPUSH  = 7'b0100000,
    ST_END    = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  // Template registers
  logic signed [31:0] accel_x_r, accel_y_r, alpha_rate_r;
  logic        [16:0] start_alpha_r;
  logic        [7:0]  base_color_r;

  // Item and walk state
  in_item_t           item_r;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [3:0]         step_r, step_nxt;
  logic [POOL_SIZE-1:0] live_r;
  logic [SLOT_W-1:0]  hint_slot_r;
  logic               hint_valid_r;

  // Datapath registers
  logic        [15:0]      dt_r;
  logic        [31:0]      dt2_r;
  logic signed [33:0]      alpha_r;
  logic signed [ACC_W-1:0] acc_r;
  logic signed [31:0]      x_r, y_r, z_r;
  logic signed [65:0]      prod_r;
  logic signed [32:0]      mul_a, mul_b;

  // Result staging
  out_item_t res_r;
  out_item_t pend_r;
  logic      pend_valid_r;
  logic      out_valid_r;
  out_item_t out_data_r;
  logic      out_free;
  logic      out_load;
  out_item_t spawn_res;
  out_item_t end_res;

  // Slot memory
  slot_rec_t           rec_rd;
  slot_rec_t           rec_wr;
  logic                ram_we, ram_re;
  logic [SLOT_W-1:0]   ram_waddr;
  logic [REC_W-1:0]    ram_rdata;

  logic [SLOT_W-1:0] idx;
  logic              use_hint;
  logic              found;
  logic [SLOT_W-1:0] sel;
  logic              at_end;
  out_item_t         new_res;
  logic [31:0]       elapsed;
  logic signed [ACC_W-1:0] pos_sum;
  logic signed [ACC_W-1:0] z_sum;

  assign idx      = cnt_r[SLOT_W-1:0];
  assign at_end   = (cnt_r == CNT_W'(POOL_SIZE - 1));
  assign use_hint = hint_valid_r && !live_r[hint_slot_r];
  assign found    = use_hint || !live_r[idx];
  assign sel      = use_hint ? hint_slot_r : idx;
  assign out_free = !out_valid_r || out_ready;

  // Load the output register from the spawn answer, a held survivor or the closing beat.
  assign out_load = out_free && ((state_r == ST_SPUSH) || (state_r == ST_END) ||
                                 ((state_r == ST_TPUSH) && pend_valid_r));

  assign in_ready  = (state_r == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign rec_rd = slot_rec_t'(ram_rdata);

  always_comb begin
    rec_wr.birth_time  = item_r.now_ms;
    rec_wr.origin_x    = item_r.pos_x;
    rec_wr.origin_y    = item_r.pos_y;
    rec_wr.origin_z    = item_r.pos_z;
    rec_wr.speed_x     = item_r.vel_x;
    rec_wr.speed_y     = item_r.vel_y;
    rec_wr.speed_z     = item_r.vel_z;
    rec_wr.pull_x      = accel_x_r;
    rec_wr.pull_y      = accel_y_r;
    rec_wr.alpha_start = start_alpha_r;
    rec_wr.alpha_slope = alpha_rate_r;
    rec_wr.palette     = base_color_r;
  end

  assign ram_we    = (state_r == ST_FIND) && found;
  assign ram_waddr = sel;
  assign ram_re    = (state_r == ST_RD) && live_r[idx];

  ppu_ram #(
    .WIDTH (REC_W),
    .DEPTH (POOL_SIZE)
  ) u_slot_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (REC_W'(rec_wr)),
    .re    (ram_re),
    .raddr (idx),
    .rdata (ram_rdata)
  );

  // Shared multiplier operand select, one product per cycle.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (step_r)
      4'd1: begin
        mul_a = 33'(rec_rd.alpha_slope);
        mul_b = $signed({17'b0, dt_r});
      end
      4'd2: begin
        mul_a = $signed({17'b0, dt_r});
        mul_b = $signed({17'b0, dt_r});
      end
      4'd3: begin
        mul_a = 33'(rec_rd.speed_x);
        mul_b = $signed({17'b0, dt_r});
      end
      4'd4: begin
        mul_a = 33'(rec_rd.pull_x);
        mul_b = $signed({1'b0, dt2_r});
      end
      4'd5: begin
        mul_a = 33'(rec_rd.speed_y);
        mul_b = $signed({17'b0, dt_r});
      end
      4'd6: begin
        mul_a = 33'(rec_rd.pull_y);
        mul_b = $signed({1'b0, dt2_r});
      end
      4'd7: begin
        mul_a = 33'(rec_rd.speed_z);
        mul_b = $signed({17'b0, dt_r});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign elapsed = item_r.now_ms - rec_rd.birth_time;
  // Add the floored pull term to the running position.
  assign pos_sum = acc_r + ACC_W'($signed(prod_r[64:16]));
  assign z_sum   = ACC_W'(rec_rd.origin_z) + ACC_W'($signed(prod_r[48:0]));

  always_comb begin
    new_res             = '0;
    new_res.is_particle = 1'b1;
    new_res.slot        = 6'(idx);
    new_res.out_x       = x_r;
    new_res.out_y       = y_r;
    new_res.out_z       = z_r;
    new_res.out_alpha   = (alpha_r > 34'sd65536) ? ALPHA_ONE : alpha_r[16:0];
    new_res.out_color   = rec_rd.palette;
  end

  always_comb begin
    spawn_res      = '0;
    spawn_res.last = 1'b1;
    if (found) begin
      spawn_res.spawn_ok = 1'b1;
      spawn_res.slot     = 6'(sel);
    end
  end

  // Closing tick beat: the held survivor, or an empty answer.
  always_comb begin
    end_res      = pend_valid_r ? pend_r : '0;
    end_res.last = 1'b1;
  end

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    step_nxt  = step_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cnt_nxt   = '0;
          state_nxt = (in_data.kind == KIND_SPAWN) ? ST_FIND : ST_RD;
        end
      end
      ST_FIND: begin
        if (found || at_end) begin
          state_nxt = ST_SPUSH;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_SPUSH: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_RD: begin
        if (live_r[idx]) begin
          step_nxt  = '0;
          state_nxt = ST_CALC;
        end else if (at_end) begin
          state_nxt = ST_END;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_CALC: begin
        step_nxt = step_r + 1'b1;
        if (step_r == 4'd3 && (alpha_r[33] || alpha_r == '0)) begin
          // Slot dies: skip the position work.
          if (at_end) begin
            state_nxt = ST_END;
          end else begin
            cnt_nxt   = cnt_r + 1'b1;
            state_nxt = ST_RD;
          end
        end else if (step_r == 4'd8) begin
          state_nxt = ST_TPUSH;
        end
      end
      ST_TPUSH: begin
        if (!pend_valid_r || out_free) begin
          if (at_end) begin
            state_nxt = ST_END;
          end else begin
            cnt_nxt   = cnt_r + 1'b1;
            state_nxt = ST_RD;
          end
        end
      end
      ST_END: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      cnt_r         <= '0;
      step_r        <= '0;
      live_r        <= '0;
      hint_slot_r   <= '0;
      hint_valid_r  <= 1'b1;
      pend_valid_r  <= 1'b0;
      out_valid_r   <= 1'b0;
      accel_x_r     <= '0;
      accel_y_r     <= '0;
      start_alpha_r <= ALPHA_ONE;
      alpha_rate_r  <= '0;
      base_color_r  <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      step_r  <= step_nxt;

      if (cfg_valid) begin
        unique case (cfg_index)
          REG_ACCEL_X:     accel_x_r     <= cfg_data;
          REG_ACCEL_Y:     accel_y_r     <= cfg_data;
          REG_START_ALPHA: start_alpha_r <= cfg_data[16:0];
          REG_ALPHA_RATE:  alpha_rate_r  <= cfg_data;
          REG_BASE_COLOR:  base_color_r  <= cfg_data[7:0];
          default: ;
        endcase
      end

      // Fill the output register, else drain it when taken.
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        ST_FIND: begin
          if (found) begin
            live_r[sel]  <= 1'b1;
            hint_valid_r <= 1'b0;
          end
        end
        ST_CALC: begin
          if (step_r == 4'd3 && (alpha_r[33] || alpha_r == '0)) begin
            live_r[idx]  <= 1'b0;
            hint_slot_r  <= idx;
            hint_valid_r <= 1'b1;
          end
        end
        ST_TPUSH: begin
          if (!pend_valid_r || out_free) begin
            pend_valid_r <= 1'b1;
          end
        end
        ST_END: begin
          if (out_free) begin
            pend_valid_r <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    if (in_valid && in_ready) begin
      item_r <= in_data;
    end
    unique case (state_r)
      ST_FIND: begin
        res_r <= spawn_res;
      end
      ST_SPUSH: begin
        if (out_free) begin
          out_data_r <= res_r;
        end
      end
      ST_CALC: begin
        unique case (step_r)
          4'd0: dt_r    <= (|elapsed[31:16]) ? DT_MAX : elapsed[15:0];
          4'd2: alpha_r <= $signed({17'b0, rec_rd.alpha_start}) +
                           34'($signed(prod_r[48:16]));
          4'd3: dt2_r   <= prod_r[31:0];
          4'd4: acc_r   <= ACC_W'(rec_rd.origin_x) + ACC_W'($signed(prod_r[48:0]));
          4'd5: x_r     <= sat32(pos_sum);
          4'd6: acc_r   <= ACC_W'(rec_rd.origin_y) + ACC_W'($signed(prod_r[48:0]));
          4'd7: y_r     <= sat32(pos_sum);
          4'd8: z_r     <= sat32(z_sum);
          default: ;
        endcase
      end
      ST_TPUSH: begin
        if (!pend_valid_r || out_free) begin
          pend_r <= new_res;
          if (pend_valid_r) begin
            out_data_r <= pend_r;
          end
        end
      end
      ST_END: begin
        if (out_free) begin
          out_data_r <= end_res;
        end
      end
      default: ;
    endcase
  end

  // A claimed slot is live right after the claim.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FIND && found) |=> live_r[$past(sel)])
    else $error("claimed slot not marked live");

  // The walk's closing beat always carries last.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_END && out_free) |=> (out_valid_r && out_data_r.last))
    else $error("tick closing beat without last");

  // A held survivor is never a spawn answer.
  assert property (@(posedge clk) disable iff (!rst_n)
    pend_valid_r |-> (pend_r.is_particle && !pend_r.spawn_ok))
    else $error("pending result is not a particle");

  // An accepted input beat starts a spawn search or a tick walk.
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == ST_FIND || state_r == ST_RD))
    else $error("accepted beat did not start work");

endmodule

FILE: rtl/core/ppu_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ppu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
